### hdl/ycc_pkg.sv
// ----------------------------------------------------------------------------
// ycc_pkg: shared definitions for the RGB to YCbCr 4:2:0 converter
// Holds the lane geometry, the BT.601 fixed-point coefficients and the
// result type that travels from the merge stage to the output port.
// ----------------------------------------------------------------------------
package ycc_pkg;

  // Lane geometry: eight pixels per group, chroma from every second pixel.
  localparam int unsigned LANES         = 8;
  localparam int unsigned LANE_SHIFT    = $clog2(LANES);
  localparam int unsigned CHROMA_LANES  = LANES / 2;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned LANES_W       = LANES * PIX_W;
  localparam int unsigned CHROMA_W      = CHROMA_LANES * PIX_W;

  // Row width register.
  localparam int unsigned ROW_WIDTH_W      = 13;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd640;
  localparam int unsigned MAX_ROW_PIXELS_DEF = 4096;

  // Accumulator width: every sum below stays inside 16 unsigned bits.
  localparam int unsigned ACC_W = 16;

  // Luma coefficients and offsets.
  localparam logic [ACC_W-1:0] Y_COEF_R   = 16'd66;
  localparam logic [ACC_W-1:0] Y_COEF_G   = 16'd129;
  localparam logic [ACC_W-1:0] Y_COEF_B   = 16'd25;
  localparam logic [ACC_W-1:0] ROUND_BIAS = 16'd128;
  localparam logic [PIX_W-1:0] Y_OFFSET   = 8'd16;

  // Chroma coefficients (magnitudes, signs applied in the lane).
  localparam logic [ACC_W-1:0] CB_COEF_R = 16'd38;
  localparam logic [ACC_W-1:0] CB_COEF_G = 16'd74;
  localparam logic [ACC_W-1:0] CB_COEF_B = 16'd112;
  localparam logic [ACC_W-1:0] CR_COEF_R = 16'd112;
  localparam logic [ACC_W-1:0] CR_COEF_G = 16'd94;
  localparam logic [ACC_W-1:0] CR_COEF_B = 16'd18;

  // Rounding bias plus the +128 output offset moved above the shift
  // (128 << 8), which keeps the chroma sum positive.
  localparam logic [ACC_W-1:0] CHROMA_BIAS = 16'd32896;

  // One converted group as it leaves the merge stage.
  typedef struct packed {
    logic                chroma_valid;
    logic [CHROMA_W-1:0] red_chroma;
    logic [CHROMA_W-1:0] blue_chroma;
    logic [LANES_W-1:0]  luma;
  } ycc_result_t;

endpackage

### hdl/ycc_luma_lane.sv
// ----------------------------------------------------------------------------
// ycc_luma_lane: luma of one pixel
// Y = ((66R + 129G + 25B + 128) >> 8) + 16, wrapped to eight bits.
// ----------------------------------------------------------------------------
module ycc_luma_lane
  import ycc_pkg::*;
(
  input  logic [PIX_W-1:0] red_i,
  input  logic [PIX_W-1:0] green_i,
  input  logic [PIX_W-1:0] blue_i,
  output logic [PIX_W-1:0] luma_o
);

  logic [ACC_W-1:0] acc;

  // The weighted sum peaks near 56k, so 16 bits never overflow.
  assign acc = Y_COEF_R * ACC_W'(red_i) + Y_COEF_G * ACC_W'(green_i)
             + Y_COEF_B * ACC_W'(blue_i) + ROUND_BIAS;

  assign luma_o = acc[ACC_W-1:ACC_W-PIX_W] + Y_OFFSET;

endmodule

### hdl/ycc_chroma_lane.sv
// ----------------------------------------------------------------------------
// ycc_chroma_lane: Cb and Cr of one even pixel
// Cb = ((-38R - 74G + 112B + 128) >> 8) + 128 and
// Cr = ((112R - 94G - 18B + 128) >> 8) + 128, floor shift, eight bits.
// ----------------------------------------------------------------------------
module ycc_chroma_lane
  import ycc_pkg::*;
(
  input  logic [PIX_W-1:0] red_i,
  input  logic [PIX_W-1:0] green_i,
  input  logic [PIX_W-1:0] blue_i,
  output logic [PIX_W-1:0] blue_chroma_o,
  output logic [PIX_W-1:0] red_chroma_o
);

  logic [ACC_W-1:0] cb_acc;
  logic [ACC_W-1:0] cr_acc;

  // With the +128 offset folded in above the shift, both sums stay between
  // about 4k and 61k, so modulo-2^16 arithmetic gives the exact value and
  // the floor shift becomes a plain bit select.
  assign cb_acc = CHROMA_BIAS + CB_COEF_B * ACC_W'(blue_i)
                - CB_COEF_R * ACC_W'(red_i) - CB_COEF_G * ACC_W'(green_i);
  assign cr_acc = CHROMA_BIAS + CR_COEF_R * ACC_W'(red_i)
                - CR_COEF_G * ACC_W'(green_i) - CR_COEF_B * ACC_W'(blue_i);

  assign blue_chroma_o = cb_acc[ACC_W-1:ACC_W-PIX_W];
  assign red_chroma_o  = cr_acc[ACC_W-1:ACC_W-PIX_W];

endmodule

### hdl/ycc_row_ctrl.sv
// ----------------------------------------------------------------------------
// ycc_row_ctrl: row width register and row parity tracking
// Counts accepted groups along the row and flips the row parity when the
// last group of a row goes by.
// ----------------------------------------------------------------------------
module ycc_row_ctrl
  import ycc_pkg::*;
#(
  parameter int unsigned MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_wr_en_i,
  input  logic [ROW_WIDTH_W-1:0] cfg_wr_data_i,
  input  logic                   accept_i,
  output logic                   odd_row_o
);

  localparam int unsigned GROUPS_MAX = MAX_ROW_PIXELS / LANES;
  localparam int unsigned GROUP_W    = (GROUPS_MAX > 1) ? $clog2(GROUPS_MAX) : 1;
  localparam int unsigned RAW_W      = ROW_WIDTH_W - LANE_SHIFT;
  localparam int unsigned LIM_W0     = $clog2(GROUPS_MAX + 1);
  localparam int unsigned CNT_W      = ((LIM_W0 > RAW_W) ? LIM_W0 : RAW_W) + 1;

  logic [ROW_WIDTH_W-1:0] row_width_q;
  logic [GROUP_W-1:0]     group_q, group_d;
  logic                   odd_row_q, odd_row_d;
  logic [CNT_W-1:0]       raw_groups;
  logic [CNT_W-1:0]       group_limit;
  logic                   row_end;

  // Groups per row: width / 8, at least one, at most MAX_ROW_PIXELS / 8.
  assign raw_groups = CNT_W'(row_width_q[ROW_WIDTH_W-1:LANE_SHIFT]);

  always_comb begin
    priority if (raw_groups == '0) begin
      group_limit = CNT_W'(1);
    end else if (raw_groups > CNT_W'(GROUPS_MAX)) begin
      group_limit = CNT_W'(GROUPS_MAX);
    end else begin
      group_limit = raw_groups;
    end
  end

  // A counter already at or past a shortened row's end closes the row now.
  assign row_end = (CNT_W'(group_q) + CNT_W'(1)) >= group_limit;

  always_comb begin
    group_d   = group_q;
    odd_row_d = odd_row_q;
    if (accept_i) begin
      if (row_end) begin
        group_d   = '0;
        odd_row_d = ~odd_row_q;
      end else begin
        group_d = group_q + GROUP_W'(1);
      end
    end
  end

  // Configuration register and position state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RESET;
      group_q     <= '0;
      odd_row_q   <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        row_width_q <= cfg_wr_data_i;
      end
      group_q   <= group_d;
      odd_row_q <= odd_row_d;
    end
  end

  assign odd_row_o = odd_row_q;

  // The group index never reaches the largest row length.
  a_group_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(group_q) < CNT_W'(GROUPS_MAX))
    else $error("group index out of range");

  // A parity flip always starts the next row at its first group.
  a_flip_restarts_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && row_end) |=> (group_q == '0 && odd_row_q != $past(odd_row_q)))
    else $error("row end did not restart the row");

endmodule

### hdl/ycc_out_buf.sv
// ----------------------------------------------------------------------------
// ycc_out_buf: lane merge stage and output register with skid entry
// Packs the lane results into one result, blanks chroma on odd rows, and
// holds it in an output register backed by a skid entry so the input side
// can take one more request while a result waits.
// ----------------------------------------------------------------------------
module ycc_out_buf
  import ycc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [LANES_W-1:0]  luma_i,
  input  logic [CHROMA_W-1:0] blue_chroma_i,
  input  logic [CHROMA_W-1:0] red_chroma_i,
  input  logic                odd_row_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output ycc_result_t         result_o
);

  ycc_result_t merged;
  ycc_result_t out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        accept;
  logic        out_free;

  // Merge: odd rows carry no chroma samples.
  always_comb begin
    merged.luma         = luma_i;
    merged.blue_chroma  = odd_row_i ? '0 : blue_chroma_i;
    merged.red_chroma   = odd_row_i ? '0 : red_chroma_i;
    merged.chroma_valid = ~odd_row_i;
  end

  assign s_ready_o = ~skid_valid_q;
  assign accept    = s_valid_i & s_ready_o;
  assign out_free  = ~out_valid_q | m_ready_i;

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q  <= skid_valid_q | accept;
        skid_valid_q <= 1'b0;
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= merged;
      end
    end else if (accept) begin
      skid_q <= merged;
    end
  end

  assign m_valid_o = out_valid_q;
  assign result_o  = out_q;

  // The skid entry is only ever filled behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds data while output register is empty");

  // A request taken while the output stalls lands in the skid entry.
  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && out_valid_q && !m_ready_i) |=> skid_valid_q)
    else $error("request lost during output stall");

endmodule

### hdl/rgb_to_ycbcr_420_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_420_converter: BT.601 RGB888 to YCbCr 4:2:0, eight pixels wide
// Top level: eight luma lanes, four chroma lanes, row tracking and the
// output stage.
// ----------------------------------------------------------------------------
// The block takes one request of eight RGB888 pixels per clock cycle while
// it is ready and registers its result in the output stage. All eight luma
// lanes and four chroma lanes compute in parallel, combinationally, so the
// sustained rate is one group per cycle whenever the output side is ready;
// a two-entry output stage (output register plus skid entry) keeps the input
// ready for one more request while a result waits. Row parity comes from a
// group counter driven by the row width register (pixels per row, reset
// 640); even rows carry four Cb and four Cr samples from pixels 0, 2, 4 and
// 6 and set the tuser flag, odd rows carry zero chroma. Write the row width
// only while no request is in flight.
module rgb_to_ycbcr_420_converter
  import ycc_pkg::*;
#(
  parameter int unsigned MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Row width configuration.
  input  logic                   cfg_wr_en_i,
  input  logic [ROW_WIDTH_W-1:0] cfg_wr_data_i,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [3*LANES_W-1:0]   s_axis_tdata,  // red_lanes, green_lanes, blue_lanes
  // Output stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [LANES_W+2*CHROMA_W-1:0] m_axis_tdata,
                                 // luma_lanes, blue_chroma_lanes, red_chroma_lanes
  output logic                   m_axis_tuser   // chroma_valid
);

  logic [LANES_W-1:0]  red_lanes, green_lanes, blue_lanes;
  logic [LANES_W-1:0]  luma_lanes;
  logic [CHROMA_W-1:0] blue_chroma_lanes, red_chroma_lanes;
  logic                odd_row;
  logic                in_accept;
  ycc_result_t         result;

  assign red_lanes   = s_axis_tdata[LANES_W-1:0];
  assign green_lanes = s_axis_tdata[2*LANES_W-1:LANES_W];
  assign blue_lanes  = s_axis_tdata[3*LANES_W-1:2*LANES_W];
  assign in_accept   = s_axis_tvalid & s_axis_tready;

  // Luma for every pixel, chroma for every even pixel.
  for (genvar k = 0; k < LANES; k++) begin : g_luma
    ycc_luma_lane u_luma (
      .red_i   (red_lanes[k*PIX_W +: PIX_W]),
      .green_i (green_lanes[k*PIX_W +: PIX_W]),
      .blue_i  (blue_lanes[k*PIX_W +: PIX_W]),
      .luma_o  (luma_lanes[k*PIX_W +: PIX_W])
    );
  end

  for (genvar k = 0; k < CHROMA_LANES; k++) begin : g_chroma
    ycc_chroma_lane u_chroma (
      .red_i         (red_lanes[2*k*PIX_W +: PIX_W]),
      .green_i       (green_lanes[2*k*PIX_W +: PIX_W]),
      .blue_i        (blue_lanes[2*k*PIX_W +: PIX_W]),
      .blue_chroma_o (blue_chroma_lanes[k*PIX_W +: PIX_W]),
      .red_chroma_o  (red_chroma_lanes[k*PIX_W +: PIX_W])
    );
  end

  // Row position and parity.
  ycc_row_ctrl #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
  ) u_row_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .accept_i      (in_accept),
    .odd_row_o     (odd_row)
  );

  // Merge and output stage.
  ycc_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .luma_i        (luma_lanes),
    .blue_chroma_i (blue_chroma_lanes),
    .red_chroma_i  (red_chroma_lanes),
    .odd_row_i     (odd_row),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .result_o      (result)
  );

  assign m_axis_tdata = {result.red_chroma, result.blue_chroma, result.luma};
  assign m_axis_tuser = result.chroma_valid;

endmodule
